// ===== src/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== src/rpc_pkg.sv =====
`default_nettype none
package rpc_pkg;
    localparam int MaxPoints  = 256;
    localparam int CoordBits  = 24;
    localparam int IdxBits    = $clog2(MaxPoints);
    localparam int CountBits  = 9;
    localparam int TBits      = 17;
    localparam logic [TBits-1:0] TOne = 17'h10000;
    // ray delta, segment delta: CoordBits+1; products: 2*(CoordBits+1)+1
    localparam int DBits      = CoordBits + 1;
    localparam int PBits      = 2 * DBits + 1;
    // n1 = dx*65536 + t2q*sdx
    localparam int NBits      = DBits + TBits + 2;
    localparam logic ActLoad  = 1'b0;
    localparam logic ActClip  = 1'b1;

    typedef struct packed {
        logic                        action;
        logic [7:0]                  point_index;
        logic signed [CoordBits-1:0] point_x;
        logic signed [CoordBits-1:0] point_y;
        logic signed [CoordBits-1:0] start_x;
        logic signed [CoordBits-1:0] start_y;
        logic signed [CoordBits-1:0] end_x;
        logic signed [CoordBits-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordBits-1:0] clip_x;
        logic signed [CoordBits-1:0] clip_y;
        logic                        hit;
    } t_out_item;

    // divider control between sequencer and divider
    typedef struct packed {
        logic start;
        logic frac;   // 17-step fraction mode, else integer quotient
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== src/ray_polyline_clip_unit.sv =====
`default_nettype none
`include "assert_macros.svh"
// Ray/polyline clipper. Load requests (action 0) write one vertex into the
// vertex RAM. A clip request (action 1) walks every segment of the stored
// polyline on one shared multiplier and one shared restoring divider: the
// vertex reads, products and range checks for each segment, and for a
// segment that passes them the 17-step fraction division, the t1 product
// and the 44-step integer division. The input is stalled while a clip runs
// and while the result waits in the output register until taken. Vertices
// must be written before point_count covers them.
module ray_polyline_clip_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire rpc_pkg::t_in_item             i_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output rpc_pkg::t_out_item                 o_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rpc_pkg::CountBits-1:0] i_cfg_data
);
    import rpc_pkg::*;

    logic [CountBits-1:0] r_count;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 w_acc, w_busy, w_res_valid, w_div_done;
    logic [IdxBits-1:0]   w_raddr;
    logic [CoordBits-1:0] w_vx, w_vy;
    t_div_ctl             w_div_ctl;
    logic [PBits-1:0]     w_div_num;
    logic [NBits-1:0]     w_div_quot;
    logic [PBits-1:0]     w_div_den;
    t_out_item            w_res;

    assign o_stall     = w_busy || r_out_valid;
    assign w_acc       = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    rpc_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_ram_x (
        .i_clk(i_clk), .i_we(w_acc && i_data.action == ActLoad),
        .i_waddr(IdxBits'(i_data.point_index)), .i_wdata(i_data.point_x),
        .i_raddr(w_raddr), .o_rdata(w_vx));
    rpc_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_ram_y (
        .i_clk(i_clk), .i_we(w_acc && i_data.action == ActLoad),
        .i_waddr(IdxBits'(i_data.point_index)), .i_wdata(i_data.point_y),
        .i_raddr(w_raddr), .o_rdata(w_vy));

    rpc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div_ctl), .i_num(w_div_num),
        .i_den(w_div_den), .o_done(w_div_done), .o_quot(w_div_quot));

    rpc_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_acc && i_data.action == ActClip), .i_item(i_data),
        .i_count(r_count), .i_vx(w_vx), .i_vy(w_vy), .o_raddr(w_raddr),
        .o_div_ctl(w_div_ctl), .o_div_num(w_div_num), .o_div_den(w_div_den),
        .i_div_done(w_div_done), .i_div_quot(w_div_quot),
        .o_busy(w_busy), .o_res_valid(w_res_valid), .o_res(w_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                // saturate to the store depth
                r_count <= (i_cfg_data > CountBits'(MaxPoints)) ?
                           CountBits'(MaxPoints) : i_cfg_data;
            end
            if (w_res_valid) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
        if (w_res_valid) r_out <= w_res;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, w_res_valid |-> !r_out_valid)
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, r_count <= CountBits'(MaxPoints))
    `ASSERT_IMPL(a_out_holds, i_clk, i_rst_n,
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
endmodule
`default_nettype wire

// ===== src/rpc_ram.sv =====
`default_nettype none
module rpc_ram #(
    parameter int Width = 24,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/rpc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. Numerator and denominator are
// nonnegative. Fraction mode yields floor(65536*n/d) for n <= d; integer mode
// yields floor(n/d).
module rpc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rpc_pkg::t_div_ctl           i_ctl,
    input  wire logic [rpc_pkg::PBits-1:0]   i_num,
    input  wire logic [rpc_pkg::PBits-1:0]   i_den,
    output logic                             o_done,
    output logic [rpc_pkg::NBits-1:0]        o_quot
);
    import rpc_pkg::*;
    localparam int CntBits = $clog2(NBits + 1);
    localparam int RBits   = PBits + 1;

    logic               r_busy, n_busy;
    logic [CntBits-1:0] r_cnt, n_cnt;
    logic [RBits-1:0]   r_rem, n_rem;
    logic [NBits-1:0]   r_num, n_num;
    logic [NBits-1:0]   r_quot, n_quot;
    logic [PBits-1:0]   r_den, n_den;
    logic               r_frac, n_frac;
    logic               r_done, n_done;
    logic [RBits-1:0]   w_trial;
    logic [RBits:0]     w_diff;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quot = r_quot;
        n_den  = r_den;
        n_frac = r_frac;
        n_done = 1'b0;
        // fraction mode: shift in zeros after the numerator; integer: numerator bits
        w_trial = r_frac ? r_rem : {r_rem[RBits-2:0], r_num[NBits-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_frac = i_ctl.frac;
            n_den  = i_den;
            n_quot = '0;
            n_num  = NBits'(i_num);
            n_rem  = i_ctl.frac ? RBits'(i_num) : '0;
            n_cnt  = i_ctl.frac ? CntBits'(TBits) : CntBits'(NBits);
        end else if (r_busy) begin
            n_num  = {r_num[NBits-2:0], 1'b0};
            if (!w_diff[RBits]) begin
                n_quot = {r_quot[NBits-2:0], 1'b1};
                n_rem  = r_frac ? {w_diff[RBits-2:0], 1'b0} : w_diff[RBits-1:0];
            end else begin
                n_quot = {r_quot[NBits-2:0], 1'b0};
                n_rem  = r_frac ? {w_trial[RBits-2:0], 1'b0} : w_trial;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        r_den  <= n_den;
        r_frac <= n_frac;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== src/rpc_seq.sv =====
`default_nettype none
`include "assert_macros.svh"
// Sequencer: walks segments, forms products on one shared multiplier,
// drives the divider, keeps the best t and forms the clip point.
module rpc_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire rpc_pkg::t_in_item             i_item,
    input  wire logic [rpc_pkg::CountBits-1:0] i_count,
    input  wire logic [rpc_pkg::CoordBits-1:0] i_vx,
    input  wire logic [rpc_pkg::CoordBits-1:0] i_vy,
    output logic [rpc_pkg::IdxBits-1:0]        o_raddr,
    output rpc_pkg::t_div_ctl                  o_div_ctl,
    output logic [rpc_pkg::PBits-1:0]          o_div_num,
    output logic [rpc_pkg::PBits-1:0]          o_div_den,
    input  wire logic                          i_div_done,
    input  wire logic [rpc_pkg::NBits-1:0]     i_div_quot,
    output logic                               o_busy,
    output logic                               o_res_valid,
    output rpc_pkg::t_out_item                 o_res
);
    import rpc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD0   = 5'd1;   // read vertex i
    localparam logic [4:0] S_RD1   = 5'd2;   // capture vertex i, read i+1
    localparam logic [4:0] S_CAP1  = 5'd3;   // capture vertex i+1
    localparam logic [4:0] S_M0    = 5'd4;   // rdx*sdy
    localparam logic [4:0] S_M1    = 5'd5;   // rdy*sdx
    localparam logic [4:0] S_M2    = 5'd6;   // rdx*(sy-y0)
    localparam logic [4:0] S_M3    = 5'd7;   // rdy*(sx-x0)
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_DIV2  = 5'd9;
    localparam logic [4:0] S_M4    = 5'd10;  // t2q*sd
    localparam logic [4:0] S_N1    = 5'd11;
    localparam logic [4:0] S_DIV1  = 5'd12;
    localparam logic [4:0] S_NEXT  = 5'd13;
    localparam logic [4:0] S_O0    = 5'd14;  // best*rdx
    localparam logic [4:0] S_O1    = 5'd15;  // best*rdy
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]                r_st, n_st;
    logic [CountBits-1:0]      r_idx, n_idx;
    logic [CountBits-1:0]      r_cnt;
    logic signed [DBits-1:0]   r_sx, r_sy, r_rdx, r_rdy;
    logic signed [DBits-1:0]   r_x0, r_y0, r_sdx, r_sdy;
    logic signed [PBits-1:0]   r_p0, r_p1, r_den;
    logic signed [TBits:0]     r_t2q;
    logic signed [NBits-1:0]   r_n1;
    logic [TBits-1:0]          r_best;
    logic                      r_res_valid;
    t_out_item                 r_res;

    // shared multiplier
    logic signed [DBits-1:0]   w_ma, w_mb;
    logic signed [2*DBits-1:0] w_prod;
    logic signed [PBits-1:0]   w_prod_p;
    logic signed [PBits-1:0]   w_num;
    logic signed [PBits-1:0]   w_den_abs, w_num_adj;
    logic signed [DBits-1:0]   w_d1;
    logic signed [NBits-1:0]   w_n1_adj;
    logic signed [NBits-1:0]   w_clip_part;
    logic                      w_use_x;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            S_M0: begin w_ma = r_rdx; w_mb = r_sdy; end
            S_M1: begin w_ma = r_rdy; w_mb = r_sdx; end
            S_M2: begin w_ma = r_rdx; w_mb = DBits'(r_sy - r_y0); end
            S_M3: begin w_ma = r_rdy; w_mb = DBits'(r_sx - r_x0); end
            S_M4: begin
                w_ma = DBits'(r_t2q);
                w_mb = w_use_x ? r_sdx : r_sdy;
            end
            S_O0: begin w_ma = DBits'($signed({1'b0, r_best})); w_mb = r_rdx; end
            S_O1: begin w_ma = DBits'($signed({1'b0, r_best})); w_mb = r_rdy; end
            default: ;
        endcase
    end
    assign w_prod   = w_ma * w_mb;
    assign w_prod_p = PBits'(w_prod);
    assign w_use_x  = (r_rdx != '0);
    assign w_num     = r_p0 - r_p1;
    assign w_den_abs = r_den[PBits-1] ? -r_den : r_den;
    assign w_num_adj = r_den[PBits-1] ? -w_num : w_num;
    assign w_d1      = w_use_x ? r_rdx : r_rdy;
    assign w_n1_adj  = w_d1[DBits-1] ? -r_n1 : r_n1;
    // arithmetic shift is floor division by 65536
    assign w_clip_part = NBits'(r_p0 >>> 16);

    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        o_div_ctl = '0;
        o_div_num = '0;
        o_div_den = '0;
        unique case (r_st)
            S_IDLE: if (i_start) n_st = S_RD0;
            S_RD0: begin
                if (r_idx + 1'b1 >= r_cnt || r_cnt < CountBits'(2)) n_st = S_O0;
                else n_st = S_RD1;
            end
            S_RD1:  n_st = S_CAP1;
            S_CAP1: n_st = S_M0;
            S_M0:   n_st = S_M1;
            S_M1:   n_st = S_M2;
            S_M2:   n_st = S_M3;
            S_M3:   n_st = S_CHK;
            S_CHK: begin
                if (r_den == '0 || w_num_adj < 0 || w_num_adj > w_den_abs) begin
                    n_st = S_NEXT;
                end else begin
                    o_div_ctl.start = 1'b1;
                    o_div_ctl.frac  = 1'b1;
                    o_div_num = w_num_adj;
                    o_div_den = w_den_abs;
                    n_st = S_DIV2;
                end
            end
            S_DIV2: if (i_div_done) n_st = S_M4;
            S_M4:   n_st = S_N1;
            S_N1:   n_st = S_DIV1;
            S_DIV1: if (i_div_done) n_st = S_NEXT;
            S_NEXT: begin
                n_idx = r_idx + 1'b1;
                n_st  = S_RD0;
            end
            S_O0:  n_st = S_O1;
            S_O1:  n_st = S_OUT;
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        // n1 division start, issued on the cycle after n1 registers
        if (r_st == S_N1) begin
            n_st = (w_n1_adj < 0) ? S_NEXT : S_DIV1;
            if (w_n1_adj >= 0) begin
                o_div_ctl.start = 1'b1;
                o_div_ctl.frac  = 1'b0;
                o_div_num = PBits'(w_n1_adj);
                o_div_den = PBits'(w_d1[DBits-1] ? -w_d1 : w_d1);
            end
        end
        if (r_st == S_IDLE && i_start) n_idx = '0;
    end

    assign o_raddr = (r_st == S_RD1) ? IdxBits'(r_idx + 1'b1) : IdxBits'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_res_valid <= (r_st == S_OUT);
        end
        r_idx <= n_idx;
        if (r_st == S_IDLE && i_start) begin
            r_cnt  <= i_count;
            r_sx   <= DBits'(i_item.start_x);
            r_sy   <= DBits'(i_item.start_y);
            r_rdx  <= DBits'(i_item.end_x) - DBits'(i_item.start_x);
            r_rdy  <= DBits'(i_item.end_y) - DBits'(i_item.start_y);
            r_best <= TOne;
        end
        if (r_st == S_RD1) begin
            r_x0 <= DBits'($signed(i_vx));
            r_y0 <= DBits'($signed(i_vy));
        end
        if (r_st == S_CAP1) begin
            r_sdx <= DBits'($signed(i_vx)) - r_x0;
            r_sdy <= DBits'($signed(i_vy)) - r_y0;
        end
        if (r_st == S_M0 || r_st == S_M2 || r_st == S_O0) r_p0 <= w_prod_p;
        if (r_st == S_M1 || r_st == S_M3 || r_st == S_O1) r_p1 <= w_prod_p;
        if (r_st == S_M2) r_den <= r_p0 - r_p1;
        if (r_st == S_DIV2 && i_div_done) r_t2q <= (TBits+1)'(i_div_quot);
        if (r_st == S_M4) begin
            r_n1 <= (w_use_x ? NBits'(r_x0 - r_sx) : NBits'(r_y0 - r_sy)) * NBits'(65536)
                    + NBits'(w_prod);
        end
        if (r_st == S_DIV1 && i_div_done && i_div_quot < NBits'(r_best)) begin
            r_best <= TBits'(i_div_quot);
        end
        if (r_st == S_O1) begin
            r_res.clip_x <= CoordBits'(r_sx + DBits'(w_clip_part));
            r_res.hit    <= (r_best < TOne);
        end
        if (r_st == S_OUT) r_res.clip_y <= CoordBits'(r_sy + DBits'(NBits'(r_p1 >>> 16)));
    end

    assign o_busy      = (r_st != S_IDLE) || r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ASSERT_IMPL(a_best_le_one, i_clk, i_rst_n, (r_st != S_IDLE) |-> (r_best <= TOne))
    `ASSERT_IMPL(a_res_after_out, i_clk, i_rst_n, r_res_valid |-> $past(r_st) == S_OUT)
    `ASSERT_IMPL(a_div_idle_start, i_clk, i_rst_n,
        o_div_ctl.start |-> (r_st == S_CHK || r_st == S_N1))
endmodule
`default_nettype wire
